[hdl/cnu_pkg.sv]
// Package: types, widths and the binomial coefficient ROM for the unrank core.
`default_nettype none
package cnu_pkg;

	localparam int N_W    = 5;
	localparam int ROWS   = 32;
	localparam int COEF_W = 29;
	localparam int WORD_W = 31;
	localparam int RANK_W = 29;

	typedef logic [COEF_W-1:0] coef_t;
	typedef coef_t [ROWS-1:0] row_t;
	typedef row_t [ROWS-1:0] pascal_t;

	typedef struct packed {
		logic load;
		logic check;
		logic step;
	} cnu_cmd_t;

	typedef struct packed {
		logic bad;
		logic i_zero;
		logic i_one;
	} cnu_sts_t;

	function automatic pascal_t build_pascal();
		pascal_t t;
		t = '0;
		for (int i = 0; i < ROWS; i++) begin
			for (int j = 0; j < ROWS; j++) begin
				if (j == 0 || j == i) begin
					t[i][j] = coef_t'(1);
				end else if (j > i) begin
					t[i][j] = '0;
				end else begin
					t[i][j] = t[i-1][j] + t[i-1][j-1];
				end
			end
		end
		return t;
	endfunction

	localparam pascal_t PASCAL = build_pascal();

endpackage
`default_nettype wire

[hdl/cnu_datapath.sv]
// Datapath: rank, ones count, position counter, ROM row register and result word.
`default_nettype none
module cnu_datapath import cnu_pkg::*; #(
	parameter int MAX_BITS = 31
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cnu_cmd_t          cmd,
	output cnu_sts_t               sts,
	input  wire logic [N_W-1:0]    width_n,
	input  wire logic [N_W-1:0]    ones_k,
	input  wire logic [RANK_W-1:0] rank,
	output logic [WORD_W-1:0]      word,
	output logic                   bad_request
);

	logic [N_W-1:0]    n_q;
	logic [N_W-1:0]    k_q;
	logic [N_W-1:0]    i_q;
	logic [RANK_W-1:0] x_q;
	logic [WORD_W-1:0] word_q;
	logic              bad_q;
	row_t              row_q;

	coef_t          coef;
	logic           take;
	logic [N_W-1:0] pos;

	assign coef = row_q[k_q];
	assign take = x_q >= coef;
	assign pos  = i_q - N_W'(1);

	assign sts.bad    = ({1'b0, n_q} > (N_W+1)'(MAX_BITS)) || (k_q > n_q) || take;
	assign sts.i_zero = i_q == '0;
	assign sts.i_one  = i_q == N_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bad_q <= 1'b0;
		end else if (cmd.load) begin
			bad_q <= 1'b0;
		end else if (cmd.check) begin
			bad_q <= sts.bad;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q    <= width_n;
			k_q    <= ones_k;
			x_q    <= rank;
			i_q    <= width_n;
			word_q <= '0;
			row_q  <= PASCAL[width_n];
		end else if (cmd.check) begin
			row_q <= PASCAL[pos];
		end else if (cmd.step) begin
			if (take) begin
				word_q[pos] <= 1'b1;
				x_q         <= x_q - coef;
				if (k_q != '0) begin
					k_q <= k_q - N_W'(1);
				end
			end
			i_q   <= pos;
			row_q <= PASCAL[pos - N_W'(1)];
		end
	end

	assign word        = word_q;
	assign bad_request = bad_q;

endmodule
`default_nettype wire

[hdl/cnu_ctrl.sv]
// Controller: sequences load, range check, per-bit steps and the result strobe.
`default_nettype none
module cnu_ctrl import cnu_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	output logic          done,
	output cnu_cmd_t      cmd,
	input  wire cnu_sts_t sts
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHECK,
		S_STEP,
		S_DONE
	} state_t;

	state_t state_q;
	logic   done_q;

	always_comb begin
		cmd       = '0;
		cmd.load  = (state_q == S_IDLE) && start;
		cmd.check = state_q == S_CHECK;
		cmd.step  = state_q == S_STEP;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (sts.bad || sts.i_zero) begin
						state_q <= S_DONE;
						done_q  <= 1'b1;
					end else begin
						state_q <= S_STEP;
					end
				end
				S_STEP: begin
					if (sts.i_one) begin
						state_q <= S_DONE;
						done_q  <= 1'b1;
					end
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = done_q;

endmodule
`default_nettype wire

[hdl/combination_unrank_core.sv]
// Top level: combinatorial number system unranking core.
//
// channel  | handshake          | payload
// ---------+--------------------+------------------------------
// request  | start, busy        | width_n, ones_k, rank
// result   | done (1-cycle)     | word, bad_request
//
// A request runs from the accepting edge through one range check, then one
// compare-subtract step per bit position, then the result cycle that shows the done
// strobe. Busy stays high with the strobe and drops after it, so a new request is
// taken only once the previous one is finished. The shared compare-subtract unit and
// the one-row-per-cycle ROM read set the pace. A rejected request skips the steps.
// Reset clears the controller; no stall on the result side.
`default_nettype none
module combination_unrank_core import cnu_pkg::*; #(
	parameter int MAX_BITS = 31
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [N_W-1:0]    width_n,
	input  wire logic [N_W-1:0]    ones_k,
	input  wire logic [RANK_W-1:0] rank,
	output logic                   done,
	output logic [WORD_W-1:0]      word,
	output logic                   bad_request
);

	cnu_cmd_t cmd;
	cnu_sts_t sts;

	cnu_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.sts    (sts)
	);

	cnu_datapath #(
		.MAX_BITS (MAX_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.width_n     (width_n),
		.ones_k      (ones_k),
		.rank        (rank),
		.word        (word),
		.bad_request (bad_request)
	);

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe outside a transaction");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && bad_request |-> word == '0)
		else $error("rejected request with nonzero word");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done)
		else $error("accepted transaction did not start");

endmodule
`default_nettype wire
